// ===== design/nsqrt_pkg.sv =====
package nsqrt_pkg;
   localparam int unsigned MAX_STEPS = 100;
   localparam int unsigned STEP_W = 7;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF_0000;
   localparam logic [31:0] ROOT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] TOL_RESET = 32'h0001_0000;

   typedef enum logic [1:0] {
      KIND_NEG,
      KIND_ZERO,
      KIND_ITER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] radicand;
   } job_type;
endpackage

// ===== design/nsqrt_front.sv =====
module nsqrt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_radicand,
   output logic                job_valid,
   input  logic                job_take,
   output nsqrt_pkg::job_type  job
);
   import nsqrt_pkg::*;

   // two-entry queue
   job_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       wr_ptr;
   logic       push, pop;
   job_type    cls;

   always_comb begin
      cls.radicand = req_radicand;
      if (req_radicand[31]) cls.kind = KIND_NEG;
      else if (req_radicand == 32'sd0) cls.kind = KIND_ZERO;
      else cls.kind = KIND_ITER;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job       = q_ff[rd_ff];
   assign wr_ptr    = rd_ff ^ cnt_ff[0];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_in     = rd_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) q_ff[wr_ptr] <= cls;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

// ===== design/nsqrt_back.sv =====
module nsqrt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         tolerance,
   input  logic                job_valid,
   output logic                job_take,
   input  nsqrt_pkg::job_type  job,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_root,
   output logic [6:0]          rsp_steps_taken,
   output logic                rsp_negative_input
);
   import nsqrt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SQ, S_CHK, S_DIV, S_UPD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] a_ff, x_ff;
   logic [6:0]  n_ff;
   logic [63:0] sq_ff;
   logic [47:0] rem_ff;   // dividend shifts out here
   logic [47:0] quo_ff;
   logic [32:0] part_ff;  // partial remainder
   logic [5:0]  bit_ff;
   logic        neg_ff;
   logic [63:0] aa, err;
   logic [33:0] trial;
   logic [48:0] nx;

   assign aa = {16'd0, a_ff, 16'd0};
   assign err = (sq_ff >= aa) ? sq_ff - aa : aa - sq_ff;
   assign trial = {part_ff, rem_ff[47]} - {2'b00, x_ff};
   assign nx = ({17'd0, x_ff} + {1'b0, quo_ff}) >> 1;
   assign job_take = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         n_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               a_ff <= job.radicand;
               n_ff <= '0;
               unique case (job.kind)
                  KIND_NEG: begin
                     rsp_root <= NEG_ONE_Q16;
                     rsp_steps_taken <= '0;
                     rsp_negative_input <= 1'b1;
                     rsp_valid <= 1'b1;
                     state_ff <= S_OUT;
                  end
                  KIND_ZERO: begin
                     rsp_root <= '0;
                     rsp_steps_taken <= '0;
                     rsp_negative_input <= 1'b0;
                     rsp_valid <= 1'b1;
                     state_ff <= S_OUT;
                  end
                  default: begin
                     x_ff <= (job.radicand > ONE_Q16) ? job.radicand : ONE_Q16;
                     state_ff <= S_SQ;
                  end
               endcase
            end
            S_SQ: begin
               sq_ff <= {32'd0, x_ff} * {32'd0, x_ff};
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (err <= {32'd0, tolerance} || n_ff == MAX_STEPS[6:0]) begin
                  rsp_root <= x_ff;
                  rsp_steps_taken <= n_ff;
                  rsp_negative_input <= 1'b0;
                  rsp_valid <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  if (x_ff == 32'd0) x_ff <= 32'd1;
                  rem_ff <= {a_ff, 16'd0};
                  part_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= 6'd47;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // one quotient bit per cycle
               if (!trial[33]) begin
                  part_ff <= trial[32:0];
                  quo_ff <= {quo_ff[46:0], 1'b1};
               end else begin
                  part_ff <= {part_ff[31:0], rem_ff[47]};
                  quo_ff <= {quo_ff[46:0], 1'b0};
               end
               rem_ff <= {rem_ff[46:0], 1'b0};
               if (bit_ff == 6'd0) state_ff <= S_UPD;
               else bit_ff <= bit_ff - 6'd1;
            end
            S_UPD: begin
               x_ff <= (nx > {17'd0, ROOT_MAX}) ? ROOT_MAX : nx[31:0];
               n_ff <= n_ff + 7'd1;
               state_ff <= S_SQ;
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) == rsp_valid) else $error("valid out of step with state");
   a_steps_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= MAX_STEPS[6:0]) else $error("step count past cap");
   a_neg_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative_input |-> rsp_root == NEG_ONE_Q16)
      else $error("negative result without -1.0");
endmodule

// ===== design/newton_square_root_top.sv =====
// Newton-Raphson square root, signed Q16.16.
// Request channel: req_valid/req_stall carrying req_radicand. Result channel:
// rsp_valid/rsp_stall carrying rsp_root, rsp_steps_taken, rsp_negative_input.
// A transaction completes when valid is high and stall is low.
// csr_write_enable loads csr_write_data into the tolerance register (reset
// 0x10000); write it only while the block is idle.
// A two-entry queue sits between the classifying front end and the iterating
// back end, so requests are taken while a result waits.
// With the back end free, a negative or zero radicand is answered directly;
// any other radicand iterates Newton steps. Each step runs a check, a 48-bit
// bit-serial divide, an update and a square, and iteration stops once the
// error is within tolerance or at the 100-step cap.
// Items are processed one at a time; after each result is taken the back end
// returns to idle before it picks up the next queued request.
// Reset (synchronous, active high) empties the queue and drops any result.
// While rsp_stall is high the result holds; the queue fills and then stalls
// the request side.
module newton_square_root_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_radicand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_root,
   output logic [6:0]         rsp_steps_taken,
   output logic               rsp_negative_input,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);
   import nsqrt_pkg::*;

   logic [31:0] tol_ff;
   logic        job_valid, job_take;
   job_type     job;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_write_enable) tol_ff <= csr_write_data;
   end

   nsqrt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_radicand,
      .job_valid, .job_take, .job
   );

   nsqrt_back u_back (
      .clock, .reset, .tolerance(tol_ff), .job_valid, .job_take, .job,
      .rsp_valid, .rsp_stall, .rsp_root, .rsp_steps_taken, .rsp_negative_input
   );
endmodule

// ===== sim/tb_newton_square_root_top.sv =====
`timescale 1ns / 100ps

module tb_newton_square_root_top;
   import nsqrt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 12_000_000;

   typedef struct {
      logic [31:0] root;
      logic [6:0]  steps;
      logic        negative;
   } root_result_type;

   typedef struct {
      logic [31:0]     radicand;
      bit              typed;
      root_result_type result;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_radicand = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_root;
   logic [6:0]         rsp_steps_taken;
   logic               rsp_negative_input;
   logic               csr_write_enable = 1'b0;
   logic [31:0]        csr_write_data = '0;

   root_result_type expected_roots[$];
   logic [31:0]  tolerance_model = TOL_RESET;
   int unsigned  cycle_count = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  result_count = 0;
   int unsigned  capped_count = 0;
   bit           quiet = 1'b0;
   bit           hold_request = 1'b0;

   directed_row_type directed_rows[13] = '{
      '{32'h8000_0000, 1'b1, '{NEG_ONE_Q16, 7'd0, 1'b1}},
      '{32'hFFFF_FFFF, 1'b1, '{NEG_ONE_Q16, 7'd0, 1'b1}},
      '{32'hFFFF_0000, 1'b1, '{NEG_ONE_Q16, 7'd0, 1'b1}},
      '{32'h0000_0000, 1'b1, '{32'h0, 7'd0, 1'b0}},
      '{32'h0001_0000, 1'b1, '{ONE_Q16, 7'd0, 1'b0}},
      '{32'h7FFF_FFFF, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h0000_0001, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h0000_0002, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h0000_FFFF, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h0009_0000, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h4000_0000, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h7FFF_0000, 1'b0, '{32'h0, 7'd0, 1'b0}},
      '{32'h1234_5678, 1'b0, '{32'h0, 7'd0, 1'b0}}
   };

   newton_square_root_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_radicand       (req_radicand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_root           (rsp_root),
      .rsp_steps_taken    (rsp_steps_taken),
      .rsp_negative_input (rsp_negative_input),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_roots.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic root_result_type newton_root(input logic [31:0] a,
                                                   input logic [31:0] tol);
      root_result_type r;
      logic [31:0]  x;
      logic [63:0]  sq;
      logic [63:0]  scaled;
      logic [63:0]  err;
      logic [63:0]  divisor;
      logic [63:0]  next_x;
      int unsigned  n;
      bit           done;
      n = 0;
      r.negative = 1'b0;
      if (a[31]) begin
         x = NEG_ONE_Q16;
         r.negative = 1'b1;
      end else if (a == 32'h0) begin
         x = 32'h0;
      end else begin
         x = (a > ONE_Q16) ? a : ONE_Q16;
         scaled = {32'h0, a} << 16;
         done = 1'b0;
         while (!done) begin
            sq = {32'h0, x} * {32'h0, x};
            err = (sq >= scaled) ? sq - scaled : scaled - sq;
            if (err <= {32'h0, tol}) begin
               done = 1'b1;
            end else begin
               divisor = (x == 32'h0) ? 64'd1 : {32'h0, x};
               next_x = ({32'h0, x} + scaled / divisor) >> 1;
               x = (next_x > {32'h0, ROOT_MAX}) ? ROOT_MAX : next_x[31:0];
               n++;
               if (n >= MAX_STEPS) done = 1'b1;
            end
         end
      end
      r.root = x;
      r.steps = n[6:0];
      return r;
   endfunction

   // Offer one transaction, with a random gap in front of it unless quiet.
   task automatic send_radicand(input logic [31:0] a, input bit typed,
                                input root_result_type typed_result);
      root_result_type r;
      r = typed ? typed_result : newton_root(a, tolerance_model);
      if (r.steps == MAX_STEPS) capped_count++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      expected_roots.push_back(r);
      req_valid <= 1'b1;
      req_radicand <= a;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_tolerance(input logic [31:0] value);
      req_valid <= 1'b0;
      wait (expected_roots.size() == 0);
      repeat (10) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance_model = value;
   endtask

   function automatic logic [31:0] random_radicand(input bit gentle);
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(0, 99);
      k = $urandom_range(1, 181);
      if (gentle) begin
         // perfect squares converge exactly; the odd small value can run to the cap
         if (pick < 85) return (k * k) << 16;
         return $urandom_range(1, 32'h000F_FFFF);
      end
      if (pick < 12) return $urandom | 32'h8000_0000;
      if (pick < 17) return 32'h0;
      if (pick < 27) return (k * k) << 16;
      if (pick < 57) return $urandom_range(1, 32'h000F_FFFF);
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   task automatic random_phase(input int unsigned count, input bit gentle);
      root_result_type none;
      none = '{32'h0, 7'd0, 1'b0};
      for (int unsigned i = 0; i < count; i++)
         send_radicand(random_radicand(gentle), 1'b0, none);
   endtask

   // Receiver: random stall bursts, plus one long hold on request.
   always @(posedge clock) begin
      static int unsigned stall_left = 0;
      static int unsigned hold_left = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = 600;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      root_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_roots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result root=%h steps=%0d neg=%b",
                        rsp_root, rsp_steps_taken, rsp_negative_input);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root !== want.root || rsp_steps_taken !== want.steps ||
                rsp_negative_input !== want.negative) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch: expected root=%h steps=%0d neg=%b, ",
                         want.root, want.steps, want.negative);
                  $display("got root=%h steps=%0d neg=%b",
                           rsp_root, rsp_steps_taken, rsp_negative_input);
               end
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_radicand(directed_rows[i].radicand, directed_rows[i].typed,
                       directed_rows[i].result);

      write_tolerance(32'h0000_0000);
      random_phase(40, 1'b1);

      write_tolerance(32'h0010_0000);
      random_phase(100, 1'b1);

      // hold the result side long enough for the queue to back up
      write_tolerance(32'hFFFF_FFFF);
      hold_request = 1'b1;
      random_phase(130, 1'b0);

      write_tolerance(32'h1000_0000);
      random_phase(80, 1'b0);
      quiet = 1'b1;
      random_phase(50, 1'b0);

      req_valid <= 1'b0;
      wait (expected_roots.size() == 0);
      repeat (50) @(posedge clock);
      $display("%0d results checked over five tolerance settings (0 to all ones),",
               result_count);
      $display("%0d of them at the step cap", capped_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
